FILE: sv/serial_crc_frame_checker_assert.svh
// assertion macros shared by the serial crc frame checker modules
// expects signals named clk and rst_n in the module that uses them
`ifndef SERIAL_CRC_FRAME_CHECKER_ASSERT_SVH
`define SERIAL_CRC_FRAME_CHECKER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SCFC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfc assertion failed");

// consequent must hold in the cycle after the antecedent
`define SCFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfc assertion failed");

`endif

FILE: sv/scfc_pkg.sv
// shared types and constants for the serial crc frame checker
// no dependencies
package scfc_pkg;

  localparam logic [1:0]  SEL_CRC12   = 2'd0;
  localparam logic [1:0]  SEL_CRC16   = 2'd1;
  localparam logic [15:0] POLY_CRC12  = 16'h080F;
  localparam logic [15:0] POLY_CRC16  = 16'h8005;
  localparam logic [15:0] POLY_CCITT  = 16'h1021;
  localparam logic [15:0] MASK_CRC12  = 16'h0FFF;
  localparam logic [15:0] MASK_CRC16  = 16'hFFFF;
  localparam logic [4:0]  WIDTH_CRC12 = 5'd12;
  localparam logic [4:0]  WIDTH_CRC16 = 5'd16;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic        frame_ok;
    logic        whole_bytes;
    logic [15:0] remainder;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [15:0] crc_rem;
    logic [15:0] delay_line;
    logic [4:0]  bits_seen;
    logic [7:0]  byte_gather;
    logic [2:0]  bit_in_byte;
  } frame_state_t;

  // results produced by one bit, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

FILE: sv/scfc_in_if.sv
// input channel of the serial crc frame checker: one frame bit per word
// no dependencies
interface scfc_in_if;
  logic valid;
  logic ready;
  logic frame_bit;
  logic end_of_frame;

  modport source (output valid, output frame_bit, output end_of_frame, input ready);
  modport sink   (input valid, input frame_bit, input end_of_frame, output ready);
endinterface

FILE: sv/scfc_out_if.sv
// result channel of the serial crc frame checker: data bytes and frame status
// no dependencies
interface scfc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic        frame_ok;
  logic        whole_bytes;
  logic [15:0] remainder;
  logic        last_result;

  modport source (output valid, output result_kind, output data_byte, output frame_ok,
                  output whole_bytes, output remainder, output last_result, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input frame_ok,
                  input whole_bytes, input remainder, input last_result, output ready);
endinterface

FILE: sv/scfc_step.sv
// one bit step: crc division, check-bit delay, byte packing and frame status
// depends on scfc_pkg
module scfc_step (
  input  logic [1:0]            crc_sel,
  input  scfc_pkg::frame_state_t state,
  input  logic                  frame_bit,
  input  logic                  end_of_frame,
  output scfc_pkg::frame_state_t state_nxt,
  output scfc_pkg::push_t        results
);
  import scfc_pkg::*;

  logic        is_crc12;
  logic [15:0] poly;
  logic [15:0] mask;
  logic [4:0]  width;
  logic [15:0] rem_cut;
  logic        rem_top;
  logic [15:0] rem_nxt;
  logic        dly_full;
  logic        data_bit;
  logic [7:0]  gather_sh;
  logic [2:0]  bib_nxt;
  logic        byte_done;
  result_t     byte_res;
  result_t     stat_res;

  always_comb begin
    is_crc12 = (crc_sel == SEL_CRC12);
    // selector value three falls through to ccitt
    poly  = is_crc12 ? POLY_CRC12 : ((crc_sel == SEL_CRC16) ? POLY_CRC16 : POLY_CCITT);
    mask  = is_crc12 ? MASK_CRC12 : MASK_CRC16;
    width = is_crc12 ? WIDTH_CRC12 : WIDTH_CRC16;

    rem_cut = state.crc_rem & mask;
    rem_top = is_crc12 ? rem_cut[11] : rem_cut[15];
    rem_nxt = ({rem_cut[14:0], frame_bit} & mask) ^ (rem_top ? poly : 16'h0000);

    dly_full  = (state.bits_seen >= width);
    data_bit  = is_crc12 ? state.delay_line[11] : state.delay_line[15];
    gather_sh = {state.byte_gather[6:0], data_bit};
    bib_nxt   = dly_full ? 3'(state.bit_in_byte + 3'd1) : state.bit_in_byte;
    byte_done = dly_full && (state.bit_in_byte == 3'd7);

    byte_res = '0;
    byte_res.result_kind = KIND_DATA;
    byte_res.data_byte   = gather_sh;
    byte_res.last_result = !end_of_frame;

    stat_res = '0;
    stat_res.result_kind = KIND_STATUS;
    stat_res.frame_ok    = (rem_nxt == 16'h0000);
    stat_res.whole_bytes = (bib_nxt == 3'd0);
    stat_res.remainder   = rem_nxt;
    stat_res.last_result = 1'b1;

    state_nxt.crc_rem     = rem_nxt;
    state_nxt.delay_line  = {state.delay_line[14:0], frame_bit};
    state_nxt.bits_seen   = dly_full ? state.bits_seen : 5'(state.bits_seen + 5'd1);
    state_nxt.byte_gather = dly_full ? (byte_done ? 8'h00 : gather_sh) : state.byte_gather;
    state_nxt.bit_in_byte = bib_nxt;
    if (end_of_frame) begin
      state_nxt = '0;
    end

    results.res0 = byte_done ? byte_res : stat_res;
    results.res1 = stat_res;
    results.cnt  = 2'({1'b0, byte_done} + {1'b0, end_of_frame});
  end

endmodule

FILE: sv/scfc_outbuf.sv
// two-word result queue that decouples the step logic from the output handshake
// depends on scfc_pkg, scfc_out_if and the assertion macro header
`include "serial_crc_frame_checker_assert.svh"
module scfc_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  scfc_pkg::push_t push,
  output logic [1:0]      room,
  scfc_out_if.source      out_if
);
  import scfc_pkg::*;

  result_t    slot_r [2];
  result_t    slot_nxt [2];
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;
  logic [1:0] cnt_kept;
  result_t    base0;

  assign pop  = out_if.valid && out_if.ready;
  assign room = 2'(2'd2 - count_r + {1'b0, pop});

  always_comb begin
    cnt_kept  = 2'(count_r - {1'b0, pop});
    base0     = pop ? slot_r[1] : slot_r[0];
    count_nxt = 2'(cnt_kept + push.cnt);
    slot_nxt[0] = base0;
    slot_nxt[1] = slot_r[1];
    case (cnt_kept)
      2'd0: begin
        slot_nxt[0] = push.res0;
        slot_nxt[1] = push.res1;
      end
      2'd1: begin
        slot_nxt[1] = push.res0;
      end
      default: begin
        slot_nxt[1] = slot_r[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  assign out_if.valid       = (count_r != 2'd0);
  assign out_if.result_kind = slot_r[0].result_kind;
  assign out_if.data_byte   = slot_r[0].data_byte;
  assign out_if.frame_ok    = slot_r[0].frame_ok;
  assign out_if.whole_bytes = slot_r[0].whole_bytes;
  assign out_if.remainder   = slot_r[0].remainder;
  assign out_if.last_result = slot_r[0].last_result;

  `SCFC_ASSERT_SAME(a_count_range, 1'b1, count_r != 2'd3)
  `SCFC_ASSERT_SAME(a_no_overflow, push.cnt != 2'd0, push.cnt <= room)
  `SCFC_ASSERT_NEXT(a_full_holds, (count_r == 2'd2) && !pop, count_r == 2'd2)

endmodule

FILE: sv/serial_crc_frame_checker.sv
// Serial CRC frame checker. Takes one frame bit per word (MSB first), divides
// the frame by CRC-12, CRC-16 or CRC-CCITT as chosen by cfg_wdata, strips the
// trailing check bits, emits each recovered data byte as soon as it is complete
// and ends each frame with a status word (remainder, ok flag, whole-byte flag).
// Throughput is one input bit per cycle. A bit that completes a byte on the end
// of a frame yields two output words; the two-word result queue takes both at
// once, so with out_if.ready held high the input never stalls, and only a
// stalled output port holds back the input. A result word passes the input
// register, then the result queue, before it is valid on out_if. Write
// cfg_wdata only while no bit is in flight. Depends on scfc_pkg, the channel
// interfaces, scfc_step, scfc_outbuf and the assertion macro header.
`include "serial_crc_frame_checker_assert.svh"
module serial_crc_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  scfc_in_if.sink    in_if,
  scfc_out_if.source out_if,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import scfc_pkg::*;

  logic [1:0]   crc_sel_r;
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  logic         s1_bit_r;
  logic         s1_eof_r;
  frame_state_t state_r;
  frame_state_t state_nxt;
  push_t        step_res;
  push_t        push;
  logic [1:0]   room;
  logic         consume;
  logic         in_take;

  scfc_step u_step (
    .crc_sel      (crc_sel_r),
    .state        (state_r),
    .frame_bit    (s1_bit_r),
    .end_of_frame (s1_eof_r),
    .state_nxt    (state_nxt),
    .results      (step_res)
  );

  // the registered bit moves on only when the queue has room for all its words
  assign consume      = s1_valid_r && (step_res.cnt <= room);
  assign in_if.ready  = !s1_valid_r || consume;
  assign in_take      = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !consume);

  always_comb begin
    push     = step_res;
    push.cnt = consume ? step_res.cnt : 2'd0;
  end

  scfc_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_if (out_if)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_sel_r  <= SEL_CRC12;
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (cfg_we) begin
        crc_sel_r <= cfg_wdata;
      end
      s1_valid_r <= s1_valid_nxt;
      if (consume) begin
        state_r <= state_nxt;
      end
    end
    if (in_take) begin
      s1_bit_r <= in_if.frame_bit;
      s1_eof_r <= in_if.end_of_frame;
    end
  end

  `SCFC_ASSERT_NEXT(a_eof_clears, consume && s1_eof_r, state_r == '0)
  `SCFC_ASSERT_SAME(a_seen_sat, 1'b1, state_r.bits_seen <= WIDTH_CRC16)
  `SCFC_ASSERT_NEXT(a_stall_holds, s1_valid_r && !consume, s1_valid_r)

endmodule
